// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the adaptive sliding mode control unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/asmc_pkg.sv =====
// Shared types, constants and helper functions of the adaptive sliding mode control unit
package asmc_pkg;

   localparam int FracBitsDefault = 16;

   // operand and product widths of the shared multiplier
   localparam int OpWidth  = 33;
   localparam int MulWidth = 2 * OpWidth;

   // restoring divider: quotient bits below the saturation limit
   localparam int DivSteps = 31;
   localparam int CntWidth = $clog2(DivSteps);

   // pi scaled by 2^30, rounded
   localparam logic [63:0] PiQ30 = 64'd3373259426;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 31;

   localparam logic [CsrIndexWidth-1:0] CsrSurfaceGain   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrLinearGain    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrAdaptRate     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrGainFloor     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrBoundaryWidth = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrSamplePeriod  = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CsrAngularMode   = 3'd6;

   localparam logic [30:0] SurfaceGainReset   = 31'd65536;
   localparam logic [30:0] LinearGainReset    = 31'd65536;
   localparam logic [30:0] AdaptRateReset     = 31'd65536;
   localparam logic [30:0] GainFloorReset     = 31'd6554;
   localparam logic [30:0] BoundaryWidthReset = 31'd655;
   localparam logic [16:0] SamplePeriodReset  = 17'd655;

   typedef enum logic [2:0] {
      MulSurf,
      MulRate,
      MulTrap,
      MulGain,
      MulLin
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        wrap;
      logic        mul;
      mul_sel_type mul_sel;
      logic        rnd;
      logic        rnd_trap;
      logic        surf;
      logic        div_prep;
      logic        div_init;
      logic        div_step;
      logic        sw;
      logic        rate;
      logic        sum;
      logic        gain;
      logic        term;
      logic        ua;
      logic        out_load;
   } asmc_cmd_type;

   typedef struct packed {
      logic gain_above_floor;
   } asmc_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [MulWidth-1:0] v);
      logic [MulWidth-32:0] upper;
      upper = v[MulWidth-1:31];
      if ((&upper) || !(|upper)) begin
         return v[31:0];
      end else if (v[MulWidth-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

endpackage

// ===== design/asmc_ctrl.sv =====
// Sequencer of the adaptive sliding mode control unit: steps the datapath through one sample
module asmc_ctrl import asmc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  asmc_status_type status,
   output asmc_cmd_type    cmd
);

   typedef enum logic [4:0] {
      Idle,
      Wrap,
      SurfMul,
      SurfRnd,
      SurfSum,
      DivPrep,
      DivInit,
      DivStep,
      SwitchSet,
      RateMul,
      RateRnd,
      RateSet,
      TrapSum,
      TrapMul,
      TrapRnd,
      GainSet,
      TermMul,
      TermRnd,
      LinMul,
      LinRnd,
      UaCalc,
      Done
   } state_type;

   state_type             state_ff, state_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != Idle);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = MulSurf;
      unique case (state_ff)
         Idle: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = Wrap;
            end
         end
         Wrap: begin
            cmd.wrap = 1'b1;
            state_in = SurfMul;
         end
         SurfMul: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = MulSurf;
            state_in    = SurfRnd;
         end
         SurfRnd: begin
            cmd.rnd  = 1'b1;
            state_in = SurfSum;
         end
         SurfSum: begin
            cmd.surf = 1'b1;
            state_in = DivPrep;
         end
         DivPrep: begin
            cmd.div_prep = 1'b1;
            state_in     = DivInit;
         end
         DivInit: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = DivStep;
         end
         DivStep: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CntWidth'(DivSteps - 1)) begin
               state_in = SwitchSet;
            end
         end
         SwitchSet: begin
            cmd.sw = 1'b1;
            // at or below the floor the rate is the floor itself, no product needed
            state_in = status.gain_above_floor ? RateMul : RateSet;
         end
         RateMul: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = MulRate;
            state_in    = RateRnd;
         end
         RateRnd: begin
            cmd.rnd  = 1'b1;
            state_in = RateSet;
         end
         RateSet: begin
            cmd.rate = 1'b1;
            state_in = TrapSum;
         end
         TrapSum: begin
            cmd.sum  = 1'b1;
            state_in = TrapMul;
         end
         TrapMul: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = MulTrap;
            state_in    = TrapRnd;
         end
         TrapRnd: begin
            cmd.rnd      = 1'b1;
            cmd.rnd_trap = 1'b1;
            state_in     = GainSet;
         end
         GainSet: begin
            cmd.gain = 1'b1;
            state_in = TermMul;
         end
         TermMul: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = MulGain;
            state_in    = TermRnd;
         end
         TermRnd: begin
            cmd.rnd  = 1'b1;
            state_in = LinMul;
         end
         LinMul: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = MulLin;
            cmd.term    = 1'b1;
            state_in    = LinRnd;
         end
         LinRnd: begin
            cmd.rnd  = 1'b1;
            state_in = UaCalc;
         end
         UaCalc: begin
            cmd.ua   = 1'b1;
            state_in = Done;
         end
         Done: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = Idle;
            end
         end
         default: begin
            state_in = Idle;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= Idle;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/asmc_dpath.sv =====
// Datapath of the adaptive sliding mode control unit: registers, shared multiplier, divider
module asmc_dpath import asmc_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic signed [31:0]       req_target_position,
   input  logic signed [31:0]       req_measured_position,
   input  logic signed [31:0]       req_measured_velocity,
   input  asmc_cmd_type             cmd,
   output asmc_status_type          status,
   output logic signed [31:0]       rsp_control_output,
   output logic signed [31:0]       rsp_adaptive_gain_out,
   output logic signed [31:0]       rsp_surface_value
);

   localparam int DvdWidth = 32 + FRAC_BITS;
   localparam int CmpWidth = (DvdWidth > 63) ? DvdWidth : 63;
   localparam logic [63:0] PiRound =
      (PiQ30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   localparam logic signed [32:0] PiFix    = 33'(PiRound);
   localparam logic signed [32:0] TwoPiFix = 33'(2 * PiRound);

   // configuration
   logic [30:0] surface_gain_ff, linear_gain_ff, adapt_rate_ff;
   logic [30:0] gain_floor_ff, boundary_width_ff;
   logic [16:0] sample_period_ff;
   logic        angular_mode_ff;

   // controller state kept across items
   logic signed [31:0] gain_ff, prev_rate_ff;

   // per-item working registers
   logic signed [32:0]          e1_ff, e2_ff;
   logic signed [OpWidth-1:0]   mul_a, mul_b;
   logic signed [MulWidth-1:0]  mul_ff, rnd_ff, t1_ff;
   logic signed [31:0]          s_ff, sw_ff, rate_ff, ua_ff;
   logic signed [32:0]          num_ff, den_ff, sum_ff;
   logic [31:0]                 rem_ff, dsr_ff;
   logic [DivSteps-1:0]         lo_ff;
   logic                        neg_ff, ovf_ff, den_zero_ff;
   logic signed [31:0]          out_ua_ff, out_gain_ff, out_s_ff;

   // rounding
   logic [5:0]                  rnd_shift;
   logic [MulWidth-1:0]         rnd_half;
   logic signed [MulWidth-1:0]  rnd_sum;

   // divider helpers
   logic signed [32:0]  s_ext, mu_ext;
   logic [32:0]         nmag, dmag;
   logic [DvdWidth-1:0] dvd;
   logic [CmpWidth-1:0] dvd_cmp, lim_cmp;
   logic [32:0]         trial, trial_diff;
   logic                trial_ge;

   function automatic logic signed [32:0] wrap_angle(input logic signed [32:0] e);
      if (e > PiFix) begin
         return e - TwoPiFix;
      end else if (e < -PiFix) begin
         return e + TwoPiFix;
      end else begin
         return e;
      end
   endfunction

   function automatic logic signed [MulWidth-1:0] ext32(input logic signed [31:0] v);
      return {{(MulWidth-32){v[31]}}, v};
   endfunction

   assign status.gain_above_floor =
      ($signed({gain_ff[31], gain_ff}) > $signed({2'b00, gain_floor_ff}));

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MulSurf: begin
            mul_a = {2'b00, surface_gain_ff};
            mul_b = e1_ff;
         end
         MulRate: begin
            mul_a = {2'b00, adapt_rate_ff};
            mul_b = {sw_ff[31], sw_ff};
         end
         MulTrap: begin
            mul_a = {16'd0, sample_period_ff};
            mul_b = sum_ff;
         end
         MulGain: begin
            mul_a = {gain_ff[31], gain_ff};
            mul_b = {sw_ff[31], sw_ff};
         end
         MulLin: begin
            mul_a = {2'b00, linear_gain_ff};
            mul_b = {s_ff[31], s_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // round to nearest, ties away from zero: (p + half - sign) >>> n
   assign rnd_shift = cmd.rnd_trap ? 6'(FRAC_BITS + 1) : 6'(FRAC_BITS);
   assign rnd_half  = {{(MulWidth-1){1'b0}}, 1'b1} << (rnd_shift - 6'd1);
   assign rnd_sum   = mul_ff + $signed(rnd_half)
                      - $signed({{(MulWidth-1){1'b0}}, mul_ff[MulWidth-1]});

   assign s_ext  = {s_ff[31], s_ff};
   assign mu_ext = {2'b00, boundary_width_ff};
   assign nmag   = num_ff[32] ? 33'(-num_ff) : 33'(num_ff);
   assign dmag   = den_ff[32] ? 33'(-den_ff) : 33'(den_ff);
   assign dvd    = {nmag[31:0], {FRAC_BITS{1'b0}}};
   assign dvd_cmp = CmpWidth'(dvd);
   assign lim_cmp = CmpWidth'({dmag[31:0], {DivSteps{1'b0}}});

   assign trial      = {rem_ff, lo_ff[DivSteps-1]};
   assign trial_ge   = (trial >= {1'b0, dsr_ff});
   assign trial_diff = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_gain_ff   <= SurfaceGainReset;
         linear_gain_ff    <= LinearGainReset;
         adapt_rate_ff     <= AdaptRateReset;
         gain_floor_ff     <= GainFloorReset;
         boundary_width_ff <= BoundaryWidthReset;
         sample_period_ff  <= SamplePeriodReset;
         angular_mode_ff   <= 1'b0;
         gain_ff           <= '0;
         prev_rate_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CsrSurfaceGain:   surface_gain_ff   <= csr_wdata;
               CsrLinearGain:    linear_gain_ff    <= csr_wdata;
               CsrAdaptRate:     adapt_rate_ff     <= csr_wdata;
               CsrGainFloor:     gain_floor_ff     <= csr_wdata;
               CsrBoundaryWidth: boundary_width_ff <= csr_wdata;
               CsrSamplePeriod:  sample_period_ff  <= csr_wdata[16:0];
               CsrAngularMode:   angular_mode_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.gain) begin
            gain_ff      <= sat32(ext32(gain_ff) + rnd_ff);
            prev_rate_ff <= rate_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         e1_ff <= {req_target_position[31], req_target_position}
                  - {req_measured_position[31], req_measured_position};
         e2_ff <= -{req_measured_velocity[31], req_measured_velocity};
      end else if (cmd.wrap && angular_mode_ff) begin
         e1_ff <= wrap_angle(e1_ff);
         e2_ff <= wrap_angle(e2_ff);
      end
      if (cmd.mul) begin
         mul_ff <= mul_a * mul_b;
      end
      if (cmd.rnd) begin
         rnd_ff <= rnd_sum >>> rnd_shift;
      end
      if (cmd.surf) begin
         s_ff <= sat32({{(MulWidth-33){e2_ff[32]}}, e2_ff} + rnd_ff);
      end
      if (cmd.div_prep) begin
         num_ff <= s_ext - mu_ext;
         den_ff <= (s_ff[31] ? -s_ext : s_ext) - mu_ext;
      end
      if (cmd.div_init) begin
         neg_ff      <= num_ff[32] ^ den_ff[32];
         den_zero_ff <= (den_ff == '0);
         // quotient at or above 2^31 saturates, so only 31 quotient bits are formed
         ovf_ff      <= (dvd_cmp >= lim_cmp);
         dsr_ff      <= dmag[31:0];
         rem_ff      <= 32'(dvd[DvdWidth-1:DivSteps]);
         lo_ff       <= dvd[DivSteps-1:0];
      end else if (cmd.div_step) begin
         if (trial_ge) begin
            rem_ff <= trial_diff[31:0];
         end else begin
            rem_ff <= trial[31:0];
         end
         lo_ff <= {lo_ff[DivSteps-2:0], trial_ge};
      end
      if (cmd.sw) begin
         if (den_zero_ff) begin
            sw_ff <= '0;
         end else if (ovf_ff) begin
            sw_ff <= neg_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            sw_ff <= neg_ff ? -$signed({1'b0, lo_ff}) : $signed({1'b0, lo_ff});
         end
      end
      if (cmd.rate) begin
         rate_ff <= status.gain_above_floor ? sat32(rnd_ff) : $signed({1'b0, gain_floor_ff});
      end
      if (cmd.sum) begin
         sum_ff <= {rate_ff[31], rate_ff} + {prev_rate_ff[31], prev_rate_ff};
      end
      if (cmd.term) begin
         t1_ff <= rnd_ff;
      end
      if (cmd.ua) begin
         ua_ff <= sat32(-t1_ff - rnd_ff);
      end
      if (cmd.out_load) begin
         out_ua_ff   <= ua_ff;
         out_gain_ff <= gain_ff;
         out_s_ff    <= s_ff;
      end
   end

   assign rsp_control_output    = out_ua_ff;
   assign rsp_adaptive_gain_out = out_gain_ff;
   assign rsp_surface_value     = out_s_ff;

endmodule

// ===== design/adaptive_sliding_mode_control_unit.sv =====
// Adaptive sliding mode control unit: top level joining sequencer and datapath
//
// Input channel req_: one sample per item (set point, measured position and
// velocity, signed fixed point). Result channel rsp_: control value, updated
// adaptive gain and sliding surface for that sample, one result per item.
// Both channels move an item when valid is high and stall is low.
// Configuration: csr_write with csr_index and csr_wdata writes one register;
// write only while no item is in flight.
// Work per item: the 31-step restoring divider of the switching term dominates;
// the rest is passes (multiply, then round) through one shared 33x33 multiplier
// and single register updates; the rate multiply is skipped when the adaptive
// gain is at or below the gain floor.
// Only one item is worked on at a time; a new item is accepted while the
// previous result still waits in the output register.
// If the receiver stalls with a result held, the next item finishes its work
// and waits until the output register frees up.
// Reset: configuration registers return to their defaults, gain and stored rate clear to zero.
`include "assert_macros.svh"

module adaptive_sliding_mode_control_unit import asmc_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_target_position,
   input  logic signed [31:0]       req_measured_position,
   input  logic signed [31:0]       req_measured_velocity,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_control_output,
   output logic signed [31:0]       rsp_adaptive_gain_out,
   output logic signed [31:0]       rsp_surface_value,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   asmc_cmd_type    cmd;
   asmc_status_type status;

   asmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   asmc_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_target_position   (req_target_position),
      .req_measured_position (req_measured_position),
      .req_measured_velocity (req_measured_velocity),
      .cmd                   (cmd),
      .status                (status),
      .rsp_control_output    (rsp_control_output),
      .rsp_adaptive_gain_out (rsp_adaptive_gain_out),
      .rsp_surface_value     (rsp_surface_value)
   );

   // every product is rounded in the cycle right after it is formed
   `ASSERT_NEXT(a_mul_then_rnd, clock, reset, cmd.mul, cmd.rnd)
   // divider setup is always followed by its first step
   `ASSERT_NEXT(a_init_then_step, clock, reset, cmd.div_init, cmd.div_step)
   // an accepted item keeps the input side closed while it is worked on
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a fresh result appears only as the sequencer returns to idle
   `ASSERT_SAME(a_result_at_idle, clock, reset, $rose(rsp_valid), !req_stall)

endmodule
